// ===== hdl/crs_pkg.sv =====
// Shared types and constants for the circular range set engine.
// No dependencies; the controller, datapath and top refer to it by scoped names, the testbench files import it.
package crs_pkg;

  localparam int RANGE_SLOTS_DEF = 64;
  localparam int KEY_W           = 128;
  localparam int ROW_W           = 2 * KEY_W;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_BELONGS  = 2'd2,
    OP_CONTAINS = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_DRAIN1,
    ST_RES1,
    ST_SCAN2,
    ST_DRAIN2,
    ST_RES2,
    ST_WR1,
    ST_WR2,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic init1;  // capture a new word, clear first-pass trackers
    logic rd_en;  // read the slot at rd_addr
    logic scan2;  // rows arriving belong to the second pass
    logic res1;   // resolve the first pass
    logic res2;   // resolve the second pass
    logic wr1;    // write first piece, update validity
    logic wr2;    // write second piece
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;  // no second pass needed
    logic fail;   // table full
  } sts_t;

endpackage

// ===== hdl/crs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/crs_ctrl.sv =====
// Sequencer for the range set engine: two slot scans, resolve and write steps.
// Depends on crs_pkg.
module crs_ctrl #(
  parameter int RANGE_SLOTS = crs_pkg::RANGE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  crs_pkg::sts_t                  sts,
  output crs_pkg::cmd_t                  cmd,
  output logic [$clog2(RANGE_SLOTS)-1:0] rd_addr,
  output logic                           busy,
  output logic                           out_strobe
);

  localparam int AW = $clog2(RANGE_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RANGE_SLOTS - 1);

  crs_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crs_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      crs_pkg::ST_IDLE:   if (start) state_nxt = crs_pkg::ST_SCAN1;
      crs_pkg::ST_SCAN1: begin
        if (cnt_r == LAST_SLOT) state_nxt = crs_pkg::ST_DRAIN1;
        else cnt_nxt = cnt_r + 1'b1;
      end
      crs_pkg::ST_DRAIN1: state_nxt = crs_pkg::ST_RES1;
      crs_pkg::ST_RES1:   state_nxt = sts.early ? crs_pkg::ST_OUT : crs_pkg::ST_SCAN2;
      crs_pkg::ST_SCAN2: begin
        if (cnt_r == LAST_SLOT) state_nxt = crs_pkg::ST_DRAIN2;
        else cnt_nxt = cnt_r + 1'b1;
      end
      crs_pkg::ST_DRAIN2: state_nxt = crs_pkg::ST_RES2;
      crs_pkg::ST_RES2:   state_nxt = sts.fail ? crs_pkg::ST_OUT : crs_pkg::ST_WR1;
      crs_pkg::ST_WR1:    state_nxt = crs_pkg::ST_WR2;
      crs_pkg::ST_WR2:    state_nxt = crs_pkg::ST_OUT;
      crs_pkg::ST_OUT:    state_nxt = crs_pkg::ST_IDLE;
      default:            state_nxt = crs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    rd_addr    = cnt_r;
    busy       = (state_r != crs_pkg::ST_IDLE);
    out_strobe = (state_r == crs_pkg::ST_OUT);
    case (state_r)
      crs_pkg::ST_IDLE:   cmd.init1 = start;
      crs_pkg::ST_SCAN1:  cmd.rd_en = 1'b1;
      crs_pkg::ST_RES1:   cmd.res1  = 1'b1;
      crs_pkg::ST_SCAN2: begin
        cmd.rd_en = 1'b1;
        cmd.scan2 = 1'b1;
      end
      crs_pkg::ST_DRAIN2: cmd.scan2 = 1'b1;
      crs_pkg::ST_RES2:   cmd.res2  = 1'b1;
      crs_pkg::ST_WR1:    cmd.wr1   = 1'b1;
      crs_pkg::ST_WR2:    cmd.wr2   = 1'b1;
      default:            cmd       = '0;
    endcase
  end

endmodule

// ===== hdl/crs_dp.sv =====
// Datapath of the range set engine: slot store, validity bits, scan trackers,
// piece resolution and result registers. Depends on crs_pkg and crs_ram.
module crs_dp #(
  parameter int RANGE_SLOTS = crs_pkg::RANGE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crs_pkg::cmd_t                  cmd,
  input  logic [$clog2(RANGE_SLOTS)-1:0] rd_addr,
  input  logic [1:0]                     in_operation,
  input  logic [63:0]                    in_first_prefix,
  input  logic [63:0]                    in_first_suffix,
  input  logic [63:0]                    in_last_prefix,
  input  logic [63:0]                    in_last_suffix,
  input  logic [63:0]                    in_key_prefix,
  input  logic [63:0]                    in_key_suffix,
  output crs_pkg::sts_t                  sts,
  output logic                           out_found,
  output logic                           out_status,
  output logic [63:0]                    out_held_first_prefix,
  output logic [63:0]                    out_held_first_suffix,
  output logic [63:0]                    out_held_last_prefix,
  output logic [63:0]                    out_held_last_suffix
);

  localparam int AW = $clog2(RANGE_SLOTS);
  localparam int KW = crs_pkg::KEY_W;

  // captured word
  crs_pkg::op_t  op_r;
  crs_pkg::key_t first_r, last_r, key_r;

  // row pipeline
  logic                      rowv_r;
  logic [AW-1:0]             idx_r;
  logic [crs_pkg::ROW_W-1:0] rd_data;
  crs_pkg::key_t             row_s, row_e;
  logic [RANGE_SLOTS-1:0]    valid_r;
  logic                      row_live;

  // first pass trackers
  logic a_fnd_r, ge_fnd_r, all_fnd_r, h_fnd_r;
  logic [AW-1:0] a_idx_r, ge_idx_r, all_idx_r, h_idx_r;
  crs_pkg::key_t a_start_r, ge_start_r, ge_end_r, all_start_r, all_end_r;
  crs_pkg::key_t h_start_r, h_end_r;

  // second pass setup and trackers
  logic [crs_pkg::ROW_W-1:0] p1_r, p2_r;
  logic                      need1_r, need2_r, ex1_en_r, ex2_en_r;
  logic [AW-1:0]             ex1_r, ex2_r;
  crs_pkg::key_t             x_r, y_r;
  logic                      eqx_fnd_r, eqy_fnd_r, f1_fnd_r, f2_fnd_r;
  logic [AW-1:0]             eqx_r, eqy_r, f1_r, f2_r, k1_r, k2_r;

  // results
  logic          res_found_r, res_status_r;
  crs_pkg::key_t res_first_r, res_last_r;

  always_ff @(posedge clk) begin
    if (cmd.init1) begin
      op_r    <= crs_pkg::op_t'(in_operation);
      first_r <= {in_first_prefix, in_first_suffix};
      last_r  <= {in_last_prefix, in_last_suffix};
      key_r   <= {in_key_prefix, in_key_suffix};
    end
  end

  crs_ram #(.WIDTH(crs_pkg::ROW_W), .DEPTH(RANGE_SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   ((cmd.wr1 & need1_r) | (cmd.wr2 & need2_r)),
    .wr_addr (cmd.wr2 ? k2_r : k1_r),
    .wr_data (cmd.wr2 ? p2_r : p1_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) rowv_r <= 1'b0;
    else        rowv_r <= cmd.rd_en;
    idx_r <= rd_addr;
  end

  assign row_s    = rd_data[crs_pkg::ROW_W-1:KW];
  assign row_e    = rd_data[KW-1:0];
  assign row_live = valid_r[idx_r];

  // ---------------- first pass ----------------
  logic          is_add, hit_a, cand, ge_upd, all_upd, q_wrap, r_wrap, sc, lc, holds, h_upd;
  crs_pkg::key_t tgt;

  always_comb begin
    is_add  = (op_r == crs_pkg::OP_ADD);
    tgt     = is_add ? last_r : key_r;
    hit_a   = row_live && is_add && (row_e == first_r) && !a_fnd_r;
    cand    = row_live && !hit_a;
    ge_upd  = cand && (row_e >= tgt) && (!ge_fnd_r || row_e < ge_end_r);
    all_upd = cand && (!all_fnd_r || row_e < all_end_r);
    q_wrap  = first_r > last_r;
    r_wrap  = row_s > row_e;
    sc      = first_r >= row_s;
    lc      = row_e >= last_r;
    if (q_wrap == r_wrap) holds = sc && lc;
    else if (!q_wrap)     holds = sc || lc;
    else                  holds = 1'b0;
    h_upd   = row_live && holds && (!h_fnd_r || row_e < h_end_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.init1) begin
      a_fnd_r   <= 1'b0;
      ge_fnd_r  <= 1'b0;
      all_fnd_r <= 1'b0;
      h_fnd_r   <= 1'b0;
    end else if (rowv_r && !cmd.scan2) begin
      if (hit_a) begin
        a_fnd_r   <= 1'b1;
        a_idx_r   <= idx_r;
        a_start_r <= row_s;
      end
      if (ge_upd) begin
        ge_fnd_r   <= 1'b1;
        ge_idx_r   <= idx_r;
        ge_start_r <= row_s;
        ge_end_r   <= row_e;
      end
      if (all_upd) begin
        all_fnd_r   <= 1'b1;
        all_idx_r   <= idx_r;
        all_start_r <= row_s;
        all_end_r   <= row_e;
      end
      if (h_upd) begin
        h_fnd_r   <= 1'b1;
        h_idx_r   <= idx_r;
        h_start_r <= row_s;
        h_end_r   <= row_e;
      end
    end
  end

  // first pass resolution
  logic          b_fnd, merged, bel, b_wrap, above, sts_early, sts_fail;
  logic [AW-1:0] b_idx;
  crs_pkg::key_t b_start, b_end, new_first, new_last;

  always_comb begin
    b_fnd     = ge_fnd_r || all_fnd_r;
    b_idx     = ge_fnd_r ? ge_idx_r : all_idx_r;
    b_start   = ge_fnd_r ? ge_start_r : all_start_r;
    b_end     = ge_fnd_r ? ge_end_r : all_end_r;
    merged    = b_fnd && (b_start == last_r);
    new_first = a_fnd_r ? a_start_r : first_r;
    new_last  = merged ? b_end : last_r;
    // belongs: the next range by last key, wrapping to the smallest overall
    b_wrap = b_start > b_end;
    above  = key_r >= b_start;
    if (!b_fnd)               bel = 1'b0;
    else if (b_end == key_r)  bel = 1'b1;
    else if (ge_fnd_r)        bel = b_wrap ? 1'b1 : above;
    else                      bel = b_wrap ? above : 1'b0;
    sts_early = !is_add && !((op_r == crs_pkg::OP_REMOVE) && h_fnd_r);
  end

  // ---------------- second pass ----------------
  logic excl, live2;

  always_comb begin
    excl  = (ex1_en_r && (idx_r == ex1_r)) || (ex2_en_r && (idx_r == ex2_r));
    live2 = row_live && !excl;
  end

  always_ff @(posedge clk) begin
    if (cmd.res1) begin
      eqx_fnd_r <= 1'b0;
      eqy_fnd_r <= 1'b0;
      f1_fnd_r  <= 1'b0;
      f2_fnd_r  <= 1'b0;
    end else if (rowv_r && cmd.scan2) begin
      if (live2 && (row_e == x_r) && !eqx_fnd_r) begin
        eqx_fnd_r <= 1'b1;
        eqx_r     <= idx_r;
      end
      if (live2 && (row_e == y_r) && !eqy_fnd_r) begin
        eqy_fnd_r <= 1'b1;
        eqy_r     <= idx_r;
      end
      if (!live2) begin
        if (!f1_fnd_r) begin
          f1_fnd_r <= 1'b1;
          f1_r     <= idx_r;
        end else if (!f2_fnd_r) begin
          f2_fnd_r <= 1'b1;
          f2_r     <= idx_r;
        end
      end
    end
  end

  // slot choice: an equal last key wins, else the lowest free slot
  logic          ok1, ok2;
  logic [AW-1:0] k1, k2;

  always_comb begin
    k1  = eqx_fnd_r ? eqx_r : f1_r;
    ok1 = !need1_r || eqx_fnd_r || f1_fnd_r;
    if (need1_r && (y_r == x_r)) begin
      k2  = k1;
      ok2 = ok1;
    end else if (eqy_fnd_r) begin
      k2  = eqy_r;
      ok2 = 1'b1;
    end else if (need1_r && !eqx_fnd_r) begin
      k2  = f2_r;
      ok2 = f2_fnd_r;
    end else begin
      k2  = f1_r;
      ok2 = f1_fnd_r;
    end
    sts_fail = !(ok1 && (!need2_r || ok2));
  end

  assign sts = '{early: sts_early, fail: sts_fail};

  // setup, resolution and result registers
  always_ff @(posedge clk) begin
    if (cmd.res1) begin
      res_status_r <= 1'b0;
      res_found_r  <= 1'b0;
      res_first_r  <= '0;
      res_last_r   <= '0;
      need1_r      <= 1'b0;
      need2_r      <= 1'b0;
      ex1_en_r     <= 1'b0;
      ex2_en_r     <= 1'b0;
      ex1_r        <= h_idx_r;
      ex2_r        <= b_idx;
      x_r          <= first_r;
      y_r          <= h_end_r;
      p1_r         <= {h_start_r, first_r};
      p2_r         <= {last_r, h_end_r};
      case (op_r)
        crs_pkg::OP_ADD: begin
          need1_r  <= 1'b1;
          ex1_r    <= a_idx_r;
          ex1_en_r <= a_fnd_r;
          ex2_en_r <= merged;
          x_r      <= new_last;
          y_r      <= new_last;
          p1_r     <= {new_first, new_last};
        end
        crs_pkg::OP_REMOVE, crs_pkg::OP_CONTAINS: begin
          res_found_r <= h_fnd_r;
          if (h_fnd_r) begin
            res_first_r <= h_start_r;
            res_last_r  <= h_end_r;
          end
          if (op_r == crs_pkg::OP_REMOVE) begin
            need1_r  <= first_r != h_start_r;
            need2_r  <= last_r != h_end_r;
            ex1_en_r <= 1'b1;
          end
        end
        crs_pkg::OP_BELONGS: res_found_r <= bel;
        default:             res_found_r <= 1'b0;
      endcase
    end
    if (cmd.res2) begin
      k1_r <= k1;
      k2_r <= k2;
      if (sts_fail) begin
        res_status_r <= 1'b1;
        res_found_r  <= 1'b0;
        res_first_r  <= '0;
        res_last_r   <= '0;
      end
    end
  end

  // validity: clear absorbed or split slots, then mark written pieces
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.wr1) begin
        if (ex1_en_r) valid_r[ex1_r] <= 1'b0;
        if (ex2_en_r) valid_r[ex2_r] <= 1'b0;
        if (need1_r)  valid_r[k1_r]  <= 1'b1;
      end
      if (cmd.wr2 && need2_r) valid_r[k2_r] <= 1'b1;
    end
  end

  assign out_found             = res_found_r;
  assign out_status            = res_status_r;
  assign out_held_first_prefix = res_first_r[KW-1:64];
  assign out_held_first_suffix = res_first_r[63:0];
  assign out_held_last_prefix  = res_last_r[KW-1:64];
  assign out_held_last_suffix  = res_last_r[63:0];

endmodule

// ===== hdl/circular_range_set_engine.sv =====
// Top level of the circular range set engine: controller plus datapath.
// Depends on crs_pkg, crs_ctrl, crs_dp (and crs_ram below it).
//
// A word is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Every operation scans all RANGE_SLOTS
// slots of the range store through its single read port; add and a remove
// that finds a holder make a second scan to find target slots, then write up
// to two pieces unless the table is full, in which case nothing is written.
// Belongs, contains and a remove that finds no holder end after the first
// scan. The result is on the out_ ports for exactly one cycle, marked by
// out_strobe, and cannot be held off: capture it in that cycle.
// Validity bits clear at reset, so no clearing pass is needed.
module circular_range_set_engine #(
  parameter int RANGE_SLOTS = crs_pkg::RANGE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_first_prefix,
  input  logic [63:0] in_first_suffix,
  input  logic [63:0] in_last_prefix,
  input  logic [63:0] in_last_suffix,
  input  logic [63:0] in_key_prefix,
  input  logic [63:0] in_key_suffix,
  output logic        out_strobe,
  output logic        out_found,
  output logic        out_status,
  output logic [63:0] out_held_first_prefix,
  output logic [63:0] out_held_first_suffix,
  output logic [63:0] out_held_last_prefix,
  output logic [63:0] out_held_last_suffix
);

  crs_pkg::cmd_t                  cmd;
  crs_pkg::sts_t                  sts;
  logic [$clog2(RANGE_SLOTS)-1:0] rd_addr;

  // sequence the scans and writes
  crs_ctrl #(.RANGE_SLOTS(RANGE_SLOTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // hold the store and work out each word's result
  crs_dp #(.RANGE_SLOTS(RANGE_SLOTS)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .rd_addr               (rd_addr),
    .in_operation          (in_operation),
    .in_first_prefix       (in_first_prefix),
    .in_first_suffix       (in_first_suffix),
    .in_last_prefix        (in_last_prefix),
    .in_last_suffix        (in_last_suffix),
    .in_key_prefix         (in_key_prefix),
    .in_key_suffix         (in_key_suffix),
    .sts                   (sts),
    .out_found             (out_found),
    .out_status            (out_status),
    .out_held_first_prefix (out_held_first_prefix),
    .out_held_first_suffix (out_held_first_suffix),
    .out_held_last_prefix  (out_held_last_prefix),
    .out_held_last_suffix  (out_held_last_suffix)
  );

  // an accepted word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a word");

  // a full table reports nothing found and no holder
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (!out_found && out_held_first_prefix == 64'd0 &&
      out_held_first_suffix == 64'd0 && out_held_last_prefix == 64'd0 &&
      out_held_last_suffix == 64'd0))
    else $error("table full result carries data");

  // one strobe per word, and only while busy
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (busy ##1 !out_strobe))
    else $error("result strobe repeated or shown while idle");

endmodule

// ===== dv/range_set_checker.sv =====
`timescale 1ns / 1ps
// Checker for the circular range set engine: predicts each result word from its own
// copy of the range table and compares it with the out_ channel. Depends on crs_pkg.
module range_set_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_first_prefix,
  input  logic [63:0] in_first_suffix,
  input  logic [63:0] in_last_prefix,
  input  logic [63:0] in_last_suffix,
  input  logic [63:0] in_key_prefix,
  input  logic [63:0] in_key_suffix,
  input  logic        out_strobe,
  input  logic        out_found,
  input  logic        out_status,
  input  logic [63:0] out_held_first_prefix,
  input  logic [63:0] out_held_first_suffix,
  input  logic [63:0] out_held_last_prefix,
  input  logic [63:0] out_held_last_suffix,
  output int          mismatch_count,
  output int          awaited_words,
  output int          full_count
);
  import crs_pkg::*;
  localparam int SLOTS = RANGE_SLOTS_DEF;

  typedef struct {
    logic found;
    logic status;
    key_t held_first;
    key_t held_last;
  } verdict_t;

  key_t     rng_first [SLOTS];
  key_t     rng_last  [SLOTS];
  bit       rng_live  [SLOTS];
  verdict_t awaited_q [$];

  function automatic int next_by_last(key_t k, bit any);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (rng_live[i] && (any || rng_last[i] >= k))
        if (best < 0 || rng_last[i] < rng_last[best]) best = i;
    return best;
  endfunction

  function automatic int slot_ending_at(key_t k);
    for (int i = 0; i < SLOTS; i++)
      if (rng_live[i] && rng_last[i] == k) return i;
    return -1;
  endfunction

  function automatic bit put_range(key_t f, key_t l);
    int k;
    k = slot_ending_at(l);
    for (int i = 0; i < SLOTS && k < 0; i++)
      if (!rng_live[i]) k = i;
    if (k < 0) return 0;
    rng_live[k]  = 1;
    rng_first[k] = f;
    rng_last[k]  = l;
    return 1;
  endfunction

  function automatic bit slot_holds(int i, key_t f, key_t l);
    bit qwrap, iwrap, lo_ok, hi_ok;
    qwrap = f > l;
    iwrap = rng_first[i] > rng_last[i];
    lo_ok = f >= rng_first[i];
    hi_ok = rng_last[i] >= l;
    if (qwrap == iwrap) return lo_ok && hi_ok;
    if (!qwrap && iwrap) return lo_ok || hi_ok;
    return 0;
  endfunction

  function automatic int holding_slot(key_t f, key_t l);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (rng_live[i] && slot_holds(i, f, l))
        if (best < 0 || rng_last[i] < rng_last[best]) best = i;
    return best;
  endfunction

  function automatic bit key_on_ring(key_t k);
    int  r;
    bit  wrapped_round, wrap, at_or_above;
    wrapped_round = 0;
    r = next_by_last(k, 0);
    if (r < 0) begin
      r = next_by_last('0, 1);
      wrapped_round = 1;
    end
    if (r < 0) return 0;
    if (rng_last[r] == k) return 1;
    wrap        = rng_first[r] > rng_last[r];
    at_or_above = k >= rng_first[r];
    if (!wrapped_round) return wrap ? 1'b1 : at_or_above;
    return wrap ? at_or_above : 1'b0;
  endfunction

  // Apply one accepted word to the table copy and work out its result word.
  function automatic verdict_t apply_word(op_t op, key_t f, key_t l, key_t k);
    verdict_t v;
    key_t     sv_first [SLOTS];
    key_t     sv_last  [SLOTS];
    bit       sv_live  [SLOTS];
    int       a, b, h;
    bit       ok;
    v = '{1'b0, 1'b0, '0, '0};
    sv_first = rng_first;
    sv_last  = rng_last;
    sv_live  = rng_live;
    case (op)
      OP_ADD: begin
        a = slot_ending_at(f);
        if (a >= 0) begin
          f = rng_first[a];
          rng_live[a] = 0;
        end
        b = next_by_last(l, 0);
        if (b < 0) b = next_by_last('0, 1);
        if (b >= 0 && rng_first[b] == l) begin
          l = rng_last[b];
          rng_live[b] = 0;
        end
        if (!put_range(f, l)) begin
          v.status = 1;
        end
      end
      OP_REMOVE, OP_CONTAINS: begin
        h = holding_slot(f, l);
        if (h >= 0) begin
          v.found      = 1;
          v.held_first = rng_first[h];
          v.held_last  = rng_last[h];
          if (op == OP_REMOVE) begin
            ok = 1;
            rng_live[h] = 0;
            if (f != v.held_first) ok = put_range(v.held_first, f);
            if (ok && l != v.held_last) ok = put_range(l, v.held_last);
            if (!ok) v = '{1'b0, 1'b1, '0, '0};
          end
        end
      end
      default: v.found = key_on_ring(k);
    endcase
    // a full table leaves the set as it was
    if (v.status) begin
      rng_first = sv_first;
      rng_last  = sv_last;
      rng_live  = sv_live;
    end
    return v;
  endfunction

  initial begin
    mismatch_count = 0;
    full_count     = 0;
    awaited_words  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      rng_live[i]  = 0;
      rng_first[i] = '0;
      rng_last[i]  = '0;
    end
  end

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst_n) begin
      // compare before taking the next word: at most one word is in flight
      if (out_strobe) begin
        got = '{out_found, out_status,
                {out_held_first_prefix, out_held_first_suffix},
                {out_held_last_prefix, out_held_last_suffix}};
        if (awaited_q.size() == 0) begin
          $display("%0t: result word with nothing awaited (found %0b status %0b)",
                   $time, got.found, got.status);
          mismatch_count++;
        end else begin
          want = awaited_q.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.held_first !== want.held_first) begin
            $display("%0t: held first expected %h actual %h", $time,
                     want.held_first, got.held_first);
            mismatch_count++;
          end
          if (got.held_last !== want.held_last) begin
            $display("%0t: held last expected %h actual %h", $time,
                     want.held_last, got.held_last);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_word(op_t'(in_operation),
                          {in_first_prefix, in_first_suffix},
                          {in_last_prefix, in_last_suffix},
                          {in_key_prefix, in_key_suffix});
        if (want.status) full_count++;
        awaited_q.push_back(want);
      end
      awaited_words = awaited_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the circular range set engine testbench: clock, reset, stimulus and verdict.
// Depends on crs_pkg, circular_range_set_engine and range_set_checker.
module tb_top;
  import crs_pkg::*;

  localparam int  RANDOM_WORDS = 1550;
  localparam int  FILL_WORDS   = 70;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam key_t ALL_ONES    = '1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [63:0] in_first_prefix, in_first_suffix;
  logic [63:0] in_last_prefix, in_last_suffix;
  logic [63:0] in_key_prefix, in_key_suffix;
  logic        out_strobe, out_found, out_status;
  logic [63:0] out_held_first_prefix, out_held_first_suffix;
  logic [63:0] out_held_last_prefix, out_held_last_suffix;

  int mismatch_count, awaited_words, full_count;
  int cycle_count;
  int words_per_op [4];
  bit no_idle;

  // ranges that were added, kept so that removes often hit stored ranges exactly
  key_t added_first [$];
  key_t added_last  [$];

  circular_range_set_engine dut (.*);

  range_set_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Guard the run: a hang anywhere ends it as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Draw keys mostly from a small lattice so that ends and starts collide
  // and merges, splits and wrapped ranges come up often.
  function automatic key_t pick_key();
    logic [63:0] p, s;
    case ($urandom_range(0, 9))
      0, 1, 2: p = '0;
      3, 4:    p = 64'd1;
      5, 6:    p = '1;
      7:       p = 64'(~64'd0 - 1);
      default: p = rand_word();
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s = 64'($urandom_range(0, 40));
      5, 6:          s = ~64'($urandom_range(0, 3));
      default:       s = rand_word();
    endcase
    return {p, s};
  endfunction

  // Drive one word and hold it until the engine takes it; start stays high.
  task automatic send_word(op_t op, key_t f, key_t l, key_t k);
    start           <= 1'b1;
    in_operation    <= op;
    {in_first_prefix, in_first_suffix} <= f;
    {in_last_prefix, in_last_suffix}   <= l;
    {in_key_prefix, in_key_suffix}     <= k;
    do @(posedge clk); while (busy);
    words_per_op[op]++;
    if (op == OP_ADD) begin
      added_first.push_back(f);
      added_last.push_back(l);
      if (added_first.size() > 96) begin
        void'(added_first.pop_front());
        void'(added_last.pop_front());
      end
    end
  endtask

  // Drop start for a random stretch now and then, so that gaps land on every
  // phase of the scan and write-back.
  task automatic maybe_idle();
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 160)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int   pick;
    key_t f, l;
    pick = $urandom_range(0, 99);
    f = pick_key();
    l = pick_key();
    if (pick < 35) begin
      send_word(OP_ADD, f, l, key_t'(rand_word()));
    end else if (pick < 60) begin
      // remove a recorded range, a piece of one, or something arbitrary
      if (added_first.size() > 0 && $urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, added_first.size() - 1);
        f = added_first[pick];
        l = $urandom_range(0, 1) ? added_last[pick] : f;
      end
      send_word(OP_REMOVE, f, l, key_t'(rand_word()));
    end else if (pick < 80) begin
      send_word(OP_BELONGS, key_t'(rand_word()), key_t'(rand_word()), pick_key());
    end else begin
      send_word(OP_CONTAINS, f, l, key_t'(rand_word()));
    end
  endtask

  initial begin
    key_t fill_first [FILL_WORDS];
    key_t fill_last  [FILL_WORDS];
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = OP_ADD;
    in_first_prefix = '0;
    in_first_suffix = '0;
    in_last_prefix  = '0;
    in_last_suffix  = '0;
    in_key_prefix   = '0;
    in_key_suffix   = '0;
    cycle_count     = 0;
    no_idle         = 0;
    for (int i = 0; i < 4; i++) words_per_op[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, merges on both sides, wrapped ranges, splits.
    send_word(OP_BELONGS,  '0, '0, '0);
    send_word(OP_CONTAINS, 128'd1, 128'd2, '0);
    send_word(OP_REMOVE,   128'd1, 128'd2, '0);
    send_word(OP_ADD,      128'd10, 128'd20, ALL_ONES);
    send_word(OP_ADD,      128'd20, 128'd30, '0);
    send_word(OP_ADD,      128'd5, 128'd10, '0);
    send_word(OP_ADD,      ALL_ONES - 5, 128'd2, '0);
    send_word(OP_BELONGS,  '0, '0, ALL_ONES);
    send_word(OP_BELONGS,  '0, '0, 128'd3);
    send_word(OP_BELONGS,  '0, '0, 128'd5);
    send_word(OP_BELONGS,  '0, '0, 128'd30);
    send_word(OP_BELONGS,  '0, '0, 128'd31);
    send_word(OP_CONTAINS, 128'd6, 128'd8, '0);
    send_word(OP_CONTAINS, ALL_ONES - 1, 128'd1, '0);
    send_word(OP_CONTAINS, ALL_ONES - 2, ALL_ONES, '0);
    send_word(OP_CONTAINS, 128'd0, 128'd1, '0);
    send_word(OP_CONTAINS, 128'd28, 128'd4, '0);
    send_word(OP_REMOVE,   128'd12, 128'd14, '0);
    send_word(OP_REMOVE,   128'd5, 128'd5, '0);
    send_word(OP_REMOVE,   ALL_ONES - 5, 128'd2, '0);
    send_word(OP_ADD,      ALL_ONES, '0, '0);
    send_word(OP_ADD,      '0, ALL_ONES, '0);
    send_word(OP_BELONGS,  '0, '0, {64'h8000_0000_0000_0000, 64'd0});
    send_word(OP_REMOVE,   '0, ALL_ONES, '0);

    // Hold off until every awaited word has come back.
    start <= 1'b0;
    @(posedge clk);
    wait (awaited_words == 0);
    @(posedge clk);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_idle = (n >= 400 && n < 650);
      if (n == 900) begin
        // Fill the table with scattered ranges so that adds and splits run
        // out of slots, then clear them again.
        for (int i = 0; i < FILL_WORDS; i++) begin
          fill_first[i] = {rand_word(), rand_word()};
          fill_last[i]  = {rand_word(), rand_word()};
          maybe_idle();
          send_word(OP_ADD, fill_first[i], fill_last[i], '0);
        end
        for (int i = 0; i < 12; i++) begin
          maybe_idle();
          send_random();
        end
        for (int i = 0; i < FILL_WORDS; i++) begin
          maybe_idle();
          send_word(OP_REMOVE, fill_first[i], fill_last[i], '0);
        end
      end
      maybe_idle();
      send_random();
    end
    start <= 1'b0;

    @(posedge clk);
    wait (awaited_words == 0);
    repeat (200) @(posedge clk);

    $display("Ran %0d adds, %0d removes, %0d belongs and %0d contains queries",
             words_per_op[OP_ADD], words_per_op[OP_REMOVE],
             words_per_op[OP_BELONGS], words_per_op[OP_CONTAINS]);
    $display("Table-full refusals seen: %0d, in %0d cycles", full_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
